// ===== hw/rtl/hva_pkg.sv =====
// Shared constants and types for the versioned handle allocator.
package hva_pkg;

  localparam int HANDLE_W     = 22;
  localparam int VERSION_BITS = 12;
  localparam int INDEX_BITS   = HANDLE_W - VERSION_BITS;
  localparam int COUNT_W      = 11;
  localparam int CMP_W        = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
  localparam logic [COUNT_W-1:0] SLOT_LIMIT_RESET = 11'd1024;

  localparam logic REQ_CREATE  = 1'b0;
  localparam logic REQ_DESTROY = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [0:0] REG_SLOT_LIMIT = 1'b0;

  typedef logic [HANDLE_W-1:0]     handle_t;
  typedef logic [VERSION_BITS-1:0] version_t;
  typedef logic [INDEX_BITS-1:0]   index_t;
  typedef logic [COUNT_W-1:0]      count_t;

endpackage

// ===== hw/rtl/hva_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hva_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hva_cfg.sv =====
// APB register file holding the slot limit.
module hva_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hva_pkg::PADDR_W-1:0] paddr,
  input  logic [hva_pkg::PDATA_W-1:0] pwdata,
  output logic [hva_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output hva_pkg::count_t             slot_limit
);

  logic sel_limit;

  // registers sit on 4-byte boundaries; low address bits are ignored
  assign sel_limit = (paddr[hva_pkg::PADDR_W-1:2] == hva_pkg::REG_SLOT_LIMIT);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= hva_pkg::SLOT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && sel_limit) begin
      slot_limit <= pwdata[hva_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = hva_pkg::PDATA_W'(slot_limit);
    end
  end

endmodule

// ===== hw/rtl/hva_core.sv =====
// Request sequencer: reads the slot entry, updates it and the free list, registers the result.
module hva_core #(
  parameter int MAX_SLOTS = 1024,
  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int CW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hva_pkg::count_t      slot_limit,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  hva_pkg::handle_t     handle_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hva_pkg::handle_t     handle_out,
  output logic                 status,
  output hva_pkg::count_t      live_count,
  output logic                 ram_we,
  output logic [AW-1:0]        ram_waddr,
  output hva_pkg::handle_t     ram_wdata,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_raddr,
  input  hva_pkg::handle_t     ram_rdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;
  localparam int   CMP_W   = hva_pkg::CMP_W;

  logic state;
  logic state_next;

  // latched request
  logic             req;
  hva_pkg::handle_t handle;
  logic [AW-1:0]    slot;

  logic [AW-1:0]    free_head;
  logic [CW-1:0]    free_count;
  logic [CW-1:0]    fresh_next;
  hva_pkg::count_t  live_total;

  logic              accept;
  logic              finish;
  hva_pkg::index_t   req_id;
  logic              id_ok;
  hva_pkg::version_t ent_ver;
  hva_pkg::index_t   ent_link;
  logic [CMP_W-1:0]  limit;
  logic              full;
  logic              have_free;

  hva_pkg::handle_t  result;
  logic              res_status;
  logic              live_inc;
  logic              live_dec;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == ST_EXEC) && (!out_valid || out_ready);

  // read address is chosen at accept time; counters cannot move until the write
  assign ram_re    = accept;
  assign ram_raddr = (req_type == hva_pkg::REQ_DESTROY) ?
                     AW'(handle_in[hva_pkg::HANDLE_W-1:hva_pkg::VERSION_BITS]) : free_head;

  assign req_id    = handle[hva_pkg::HANDLE_W-1:hva_pkg::VERSION_BITS];
  assign id_ok     = CMP_W'(req_id) < CMP_W'(MAX_SLOTS);
  assign ent_ver   = ram_rdata[hva_pkg::VERSION_BITS-1:0];
  assign ent_link  = ram_rdata[hva_pkg::HANDLE_W-1:hva_pkg::VERSION_BITS];
  assign have_free = (free_count != '0);
  assign limit     = (CMP_W'(slot_limit) > CMP_W'(MAX_SLOTS)) ?
                     CMP_W'(MAX_SLOTS) : CMP_W'(slot_limit);
  assign full      = CMP_W'(fresh_next) >= limit;

  always_comb begin
    result     = '0;
    res_status = hva_pkg::STATUS_OK;
    live_inc   = 1'b0;
    live_dec   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = slot;
    ram_wdata  = '0;
    if (req == hva_pkg::REQ_CREATE) begin
      if (have_free) begin
        result    = {hva_pkg::INDEX_BITS'(slot), ent_ver};
        ram_we    = finish;
        ram_wdata = result;
        live_inc  = 1'b1;
      end else if (full) begin
        res_status = hva_pkg::STATUS_FULL;
      end else begin
        result    = {hva_pkg::INDEX_BITS'(fresh_next), hva_pkg::version_t'(0)};
        ram_we    = finish;
        ram_waddr = AW'(fresh_next);
        ram_wdata = result;
        live_inc  = 1'b1;
      end
    end else if (id_ok) begin
      ram_we    = finish;
      ram_wdata = {hva_pkg::INDEX_BITS'(free_head), hva_pkg::version_t'(ent_ver + 1'b1)};
      live_dec  = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= req_type;
      handle <= handle_in;
      slot   <= ram_raddr;
    end
    if (finish) begin
      handle_out <= result;
      status     <= res_status;
      live_count <= (live_inc && live_total != hva_pkg::COUNT_MAX) ? live_total + 1'b1 :
                    (live_dec && live_total != '0) ? live_total - 1'b1 : live_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      free_head  <= '0;
      free_count <= '0;
      fresh_next <= '0;
      live_total <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        if (live_inc && live_total != hva_pkg::COUNT_MAX) begin
          live_total <= live_total + 1'b1;
        end else if (live_dec && live_total != '0) begin
          live_total <= live_total - 1'b1;
        end
        if (req == hva_pkg::REQ_CREATE) begin
          if (have_free) begin
            // a link past the table end falls back to slot 0
            free_head  <= (CMP_W'(ent_link) < CMP_W'(MAX_SLOTS)) ? AW'(ent_link) : '0;
            free_count <= free_count - 1'b1;
          end else if (!full) begin
            fresh_next <= fresh_next + 1'b1;
          end
        end else if (id_ok) begin
          free_head <= slot;
          if (free_count < CW'(MAX_SLOTS)) begin
            free_count <= free_count + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/versioned_handle_allocator_unit.sv =====
// Versioned handle allocator: slot table in RAM with an in-place free list.
// Result: registered in the execute state, after the slot read issued at accept, once the output is free.
// Requests are not overlapped: the next one is taken only after the read-then-write of the slot RAM for this one.
// A waiting result does not block the next request; it stalls only at write-back.
// Reset (rst, synchronous): counters and free list head cleared, slot limit set to 1024;
// the slot RAM is not cleared; entries must be written before they are read, which the block does not enforce.
module versioned_handle_allocator_unit #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  hva_pkg::handle_t            handle_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hva_pkg::handle_t            handle_out,
  output logic                        status,
  output hva_pkg::count_t             live_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hva_pkg::PADDR_W-1:0] paddr,
  input  logic [hva_pkg::PDATA_W-1:0] pwdata,
  output logic [hva_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  hva_pkg::count_t  slot_limit;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  hva_pkg::handle_t ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  hva_pkg::handle_t ram_rdata;

  hva_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slot_limit (slot_limit)
  );

  hva_core #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .slot_limit (slot_limit),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .handle_in  (handle_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .handle_out (handle_out),
    .status     (status),
    .live_count (live_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  hva_ram #(
    .WIDTH (hva_pkg::HANDLE_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hw/rtl/hva_checker.sv =====
// Port-level checks for the versioned handle allocator, bound to the top level.
module hva_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input hva_pkg::handle_t handle_out,
  input logic             status,
  input hva_pkg::count_t  live_count
);

  // a held result keeps its payload until the transaction completes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(handle_out) && $stable(status)
      && $stable(live_count))
    else $error("held result changed");

  // a refused create never carries a handle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == hva_pkg::STATUS_FULL |-> handle_out == '0)
    else $error("full status with nonzero handle");

  // requests are never accepted back to back
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back request accept");

  // no result right out of reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind versioned_handle_allocator_unit hva_checker u_hva_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .handle_out (handle_out),
  .status     (status),
  .live_count (live_count)
);

// ===== tb/tb_versioned_handle_allocator_unit.sv =====
// Self-checking testbench for the versioned handle allocator: directed corners, random traffic.
module tb_versioned_handle_allocator_unit;

  localparam int SLOT_COUNT  = 1024;
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 300;
  localparam logic [hva_pkg::PADDR_W-1:0] SLOT_LIMIT_ADDR =
    hva_pkg::PADDR_W'(4 * hva_pkg::REG_SLOT_LIMIT);

  typedef struct {
    logic             req;
    hva_pkg::handle_t h;
    hva_pkg::handle_t exp_handle;
    logic             exp_status;
    hva_pkg::count_t  exp_live;
  } alloc_txn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic                         req_type  = hva_pkg::REQ_CREATE;
  hva_pkg::handle_t             handle_in = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  hva_pkg::handle_t             handle_out;
  logic                         status;
  hva_pkg::count_t              live_count;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [hva_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [hva_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [hva_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  versioned_handle_allocator_unit #(.MAX_SLOTS(SLOT_COUNT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .handle_in(handle_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .handle_out(handle_out), .status(status), .live_count(live_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // allocator shadow state
  hva_pkg::handle_t slot_mem [SLOT_COUNT];
  hva_pkg::index_t  m_free_head  = '0;
  hva_pkg::count_t  m_free_count = '0;
  hva_pkg::count_t  m_fresh_next = '0;
  hva_pkg::count_t  m_live       = '0;
  hva_pkg::count_t  m_limit      = hva_pkg::SLOT_LIMIT_RESET;

  alloc_txn_t       pending_q [$];
  alloc_txn_t       expected_q [$];
  hva_pkg::handle_t live_pool [$];
  alloc_txn_t       cur_txn;

  int   total_queued = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  int   send_gap     = 0;
  int   recv_gap     = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;
  logic hold_armed   = 1'b0;
  logic quiet        = 1'b0;

  function automatic alloc_txn_t predict_alloc(logic req, hva_pkg::handle_t h);
    alloc_txn_t        t;
    hva_pkg::count_t   lim;
    hva_pkg::index_t   slot;
    hva_pkg::index_t   id;
    hva_pkg::handle_t  entry;
    hva_pkg::version_t ver;
    t.req        = req;
    t.h          = h;
    t.exp_handle = '0;
    t.exp_status = hva_pkg::STATUS_OK;
    if (req == hva_pkg::REQ_CREATE) begin
      lim = (m_limit > SLOT_COUNT) ? hva_pkg::count_t'(SLOT_COUNT) : m_limit;
      if (m_free_count > 0) begin
        // pop the head of the in-place free list
        slot = m_free_head;
        entry = slot_mem[slot];
        t.exp_handle = {slot, entry[hva_pkg::VERSION_BITS-1:0]};
        slot_mem[slot] = t.exp_handle;
        m_free_head = entry[hva_pkg::HANDLE_W-1:hva_pkg::VERSION_BITS];
        m_free_count = m_free_count - 1'b1;
        if (m_live != hva_pkg::COUNT_MAX) m_live = m_live + 1'b1;
      end else if (m_fresh_next >= lim) begin
        t.exp_status = hva_pkg::STATUS_FULL;
      end else begin
        t.exp_handle = {hva_pkg::index_t'(m_fresh_next), hva_pkg::version_t'(0)};
        slot_mem[hva_pkg::index_t'(m_fresh_next)] = t.exp_handle;
        m_fresh_next = m_fresh_next + 1'b1;
        if (m_live != hva_pkg::COUNT_MAX) m_live = m_live + 1'b1;
      end
    end else begin
      id = h[hva_pkg::HANDLE_W-1:hva_pkg::VERSION_BITS];
      ver = slot_mem[id][hva_pkg::VERSION_BITS-1:0] + 1'b1;
      slot_mem[id] = {m_free_head, ver};
      m_free_head = id;
      if (m_free_count < SLOT_COUNT) m_free_count = m_free_count + 1'b1;
      if (m_live != 0) m_live = m_live - 1'b1;
    end
    t.exp_live = m_live;
    return t;
  endfunction

  task automatic push_req(logic req, hva_pkg::handle_t h);
    alloc_txn_t t;
    t = predict_alloc(req, h);
    if (req == hva_pkg::REQ_CREATE && t.exp_status == hva_pkg::STATUS_OK)
      live_pool.push_back(t.exp_handle);
    pending_q.push_back(t);
    total_queued++;
  endtask

  task automatic wait_drain();
    while (results_seen < total_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_limit(hva_pkg::count_t value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOT_LIMIT_ADDR;
    pwdata  <= hva_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    m_limit = value;
  endtask

  // noise: stale destroys of any written slot; otherwise destroy a live handle or create
  task automatic run_mix(int n, int destroy_pct, int noise_pct);
    int               i;
    int               r;
    int               k;
    hva_pkg::handle_t h;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < noise_pct && m_fresh_next > 0) begin
        h = {hva_pkg::index_t'($urandom_range(0, int'(m_fresh_next) - 1)),
             hva_pkg::version_t'($urandom)};
        push_req(hva_pkg::REQ_DESTROY, h);
      end else if (r < noise_pct + destroy_pct && live_pool.size() > 0) begin
        k = $urandom_range(0, live_pool.size() - 1);
        h = live_pool[k];
        live_pool.delete(k);
        push_req(hva_pkg::REQ_DESTROY, h);
      end else begin
        push_req(hva_pkg::REQ_CREATE, hva_pkg::handle_t'($urandom));
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(cur_txn);
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_q.size() > 0) begin
          cur_txn = pending_q.pop_front();
          req_type  <= cur_txn.req;
          handle_in <= cur_txn.h;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin : check_result
    alloc_txn_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: handle_out=%h status=%0d live_count=%0d",
                     handle_out, status, live_count);
          mismatches++;
        end else begin
          e = expected_q.pop_front();
          if (handle_out !== e.exp_handle || status !== e.exp_status ||
              live_count !== e.exp_live) begin
            if (mismatches < 10)
              $display("mismatch: req=%0d in=%h exp %h/%0d/%0d got %h/%0d/%0d",
                       e.req, e.h, e.exp_handle, e.exp_status, e.exp_live,
                       handle_out, status, live_count);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_armed && !hold_done) begin
        // long hold-off so the block backs up into its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("versioned_handle_allocator_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // zero limit: create with nothing free is refused
    write_slot_limit(11'd0);
    push_req(hva_pkg::REQ_CREATE, '1);
    wait_drain();

    // one slot: reuse, version bump, stale and duplicate destroys
    write_slot_limit(11'd1);
    push_req(hva_pkg::REQ_CREATE, '0);
    push_req(hva_pkg::REQ_CREATE, '0);
    push_req(hva_pkg::REQ_DESTROY, {hva_pkg::index_t'(0), hva_pkg::version_t'(0)});
    push_req(hva_pkg::REQ_CREATE, '0);
    push_req(hva_pkg::REQ_DESTROY, {hva_pkg::index_t'(0), hva_pkg::version_t'('1)});
    push_req(hva_pkg::REQ_DESTROY, {hva_pkg::index_t'(0), hva_pkg::version_t'(0)});
    push_req(hva_pkg::REQ_CREATE, '1);
    push_req(hva_pkg::REQ_CREATE, '0);
    push_req(hva_pkg::REQ_CREATE, '0);
    wait_drain();

    // limit lowered below used slots: freed slot still reused, fresh refused
    write_slot_limit(11'd0);
    push_req(hva_pkg::REQ_DESTROY, {hva_pkg::index_t'(0), hva_pkg::version_t'(3)});
    push_req(hva_pkg::REQ_CREATE, '0);
    push_req(hva_pkg::REQ_CREATE, '0);
    wait_drain();

    live_pool.delete();

    write_slot_limit(hva_pkg::SLOT_LIMIT_RESET);
    hold_armed <= 1'b1;
    run_mix(350, 40, 10);
    wait_drain();

    write_slot_limit(hva_pkg::count_t'($urandom_range(2, 1023)));
    run_mix(350, 55, 10);
    wait_drain();

    // oversized limit saturates; hammer slot 0 until the free count pins at its top
    write_slot_limit(11'd2047);
    while (m_free_count < SLOT_COUNT)
      push_req(hva_pkg::REQ_DESTROY, {hva_pkg::index_t'(0), hva_pkg::version_t'($urandom)});
    for (i = 0; i < 4; i++)
      push_req(hva_pkg::REQ_DESTROY, {hva_pkg::index_t'(0), hva_pkg::version_t'($urandom)});
    for (i = 0; i < 8; i++)
      push_req(hva_pkg::REQ_CREATE, hva_pkg::handle_t'($urandom));
    wait_drain();

    write_slot_limit(11'd1023);
    quiet <= 1'b1;
    run_mix(350, 45, 10);
    wait_drain();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("versioned_handle_allocator_unit verification clean");
    end else begin
      $display("versioned_handle_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
